>>> sv/integer_string_parser_core_macros.svh
// Assertion helpers shared by the checker files of the integer string parser.
// Each helper expects signals named clk and rst in the scope where it is used,
// and is switched off while reset is held.
`ifndef INTEGER_STRING_PARSER_CORE_MACROS_SVH
`define INTEGER_STRING_PARSER_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ISP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ISP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/isp_pkg.sv
`timescale 1ns / 1ps

package isp_pkg;

  // Configuration port address width: four 64-bit registers at 8-byte strides.
  localparam int ADDR_W = 5;

  typedef enum logic [1:0] {
    REG_BASE_MODE   = 2'd0,
    REG_SIGNED_MODE = 2'd1,
    REG_MIN_VALUE   = 2'd2,
    REG_MAX_VALUE   = 2'd3
  } reg_idx_t;

  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  typedef enum logic [3:0] {
    PH_FIRST,
    PH_PFX0,
    PH_WS,
    PH_SIGNED,
    PH_HEX0,
    PH_AFTERX,
    PH_DIGITS,
    PH_DONE,
    PH_JUNK,
    PH_ERR0X
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HEX_IN_DEC  = 3'd1,
    ST_JUNK        = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_BELOW_MIN   = 3'd4,
    ST_ABOVE_MAX   = 3'd5
  } status_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  localparam logic [5:0] RADIX_DEC  = 6'd10;
  localparam logic [5:0] RADIX_HEX  = 6'd16;
  localparam logic [5:0] DIGIT_NONE = 6'd63;

  localparam logic [63:0] U64_ALL = {64{1'b1}};
  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, 63'd0};

  typedef struct packed {
    logic [1:0]  base_mode;
    logic        signed_mode;
    logic [63:0] min_value;
    logic [63:0] max_value;
  } cfg_t;

  // Result of the parse stage, before the range checks.
  typedef struct packed {
    logic [63:0] value;
    status_t     status;
    logic        signed_mode;
  } fin_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Digit value of a letter or digit, DIGIT_NONE for anything else.
  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h37;
    end else begin
      t = {2'b00, DIGIT_NONE};
    end
    return t[5:0];
  endfunction

endpackage

>>> sv/isp_cfg.sv
`timescale 1ns / 1ps

module isp_cfg import isp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0]  base_mode;
  logic        signed_mode;
  logic [63:0] min_value;
  logic [63:0] max_value;
  reg_idx_t    reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode   <= 2'd0;
      signed_mode <= 1'b0;
      min_value   <= '0;
      max_value   <= U64_ALL;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE_MODE:   base_mode   <= pwdata[1:0];
        REG_SIGNED_MODE: signed_mode <= pwdata[0];
        REG_MIN_VALUE:   min_value   <= pwdata;
        REG_MAX_VALUE:   max_value   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_MODE:   prdata = {62'd0, base_mode};
      REG_SIGNED_MODE: prdata = {63'd0, signed_mode};
      REG_MIN_VALUE:   prdata = min_value;
      REG_MAX_VALUE:   prdata = max_value;
      default:         prdata = '0;
    endcase
  end

  assign cfg = '{base_mode: base_mode, signed_mode: signed_mode,
                 min_value: min_value, max_value: max_value};

endmodule

>>> sv/isp_parse.sv
`timescale 1ns / 1ps

module isp_parse import isp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  input  logic [7:0] char_byte,
  input  cfg_t       cfg,
  input  logic       check_ready,
  output logic       char_take,
  output logic       fin_valid,
  output fin_t       fin
);

  typedef struct packed {
    phase_t      phase;
    logic [63:0] acc;
    logic        hex;
    logic        neg;
    logic        sat;
    logic        lead_seen;
    logic        lead_nl;
  } pstate_t;

  localparam pstate_t PST_RESET = '{phase: PH_FIRST, acc: '0, hex: 1'b0, neg: 1'b0,
                                    sat: 1'b0, lead_seen: 1'b0, lead_nl: 1'b0};

  pstate_t     st;
  pstate_t     pre;
  pstate_t     fed;
  pstate_t     st_next;
  fin_t        fin_next;
  logic        is_nul;
  logic        fin_free;
  logic        cfg_hex;
  logic [5:0]  digit;
  logic        is_dig;
  logic [67:0] prod;
  logic [67:0] wide;
  logic        add_ovf;
  logic        ln_eff;
  logic        do_add;
  logic        run;
  logic        lead_dec;
  status_t     early;
  logic        zero_it;
  logic [63:0] fa;
  logic        fs;
  logic [63:0] neg_a;
  logic [63:0] v;
  logic        v_ovf;

  assign is_nul    = (char_byte == CH_NUL);
  assign fin_free  = !fin_valid || check_ready;
  assign char_take = char_valid && (!is_nul || fin_free);
  assign cfg_hex   = (cfg.base_mode == BASE_HEX);

  // A pending leading zero that is not followed by 'x' is a plain digit
  // of the converted text; the first character otherwise opens conversion.
  always_comb begin
    pre = st;
    if (st.phase == PH_PFX0 && char_byte != CH_LOWER_X) begin
      pre.phase     = cfg_hex ? PH_HEX0 : PH_DIGITS;
      pre.hex       = cfg_hex;
      pre.acc       = '0;
      pre.sat       = 1'b0;
      pre.neg       = 1'b0;
      pre.lead_seen = 1'b1;
      pre.lead_nl   = 1'b0;
    end else if (st.phase == PH_FIRST && !is_nul && char_byte != CH_ZERO) begin
      pre.phase = PH_WS;
      pre.hex   = cfg_hex;
    end
  end

  assign digit  = digit_of(char_byte);
  assign is_dig = pre.hex ? (digit < RADIX_HEX) : (digit < RADIX_DEC);

  // Shared multiply-add: acc * radix + digit, overflow past 64 bits saturates.
  assign prod    = pre.hex ? {pre.acc, 4'b0000}
                           : ({1'b0, pre.acc, 3'b000} + {3'b000, pre.acc, 1'b0});
  assign wide    = prod + {62'd0, digit};
  assign add_ovf = |wide[67:64];
  assign ln_eff  = pre.lead_seen ? pre.lead_nl : (char_byte == CH_LF);

  always_comb begin
    fed           = pre;
    fed.lead_seen = 1'b1;
    fed.lead_nl   = ln_eff;
    do_add        = 1'b0;
    run           = 1'b0;
    lead_dec      = 1'b0;
    case (pre.phase)
      PH_WS: begin
        if (!is_space(char_byte)) begin
          if (char_byte == CH_PLUS || char_byte == CH_MINUS) begin
            fed.neg   = (char_byte == CH_MINUS);
            fed.phase = PH_SIGNED;
          end else begin
            lead_dec = 1'b1;
          end
        end
      end
      PH_SIGNED: lead_dec = 1'b1;
      PH_HEX0: begin
        if (char_byte == CH_LOWER_X || char_byte == CH_UPPER_X) begin
          fed.phase = PH_AFTERX;
        end else begin
          fed.acc = '0;
          run     = 1'b1;
        end
      end
      PH_AFTERX: begin
        if (is_dig) begin
          fed.phase = PH_DIGITS;
          do_add    = 1'b1;
        end else begin
          fed.phase = PH_JUNK;
        end
      end
      PH_DIGITS: run = 1'b1;
      default: ;
    endcase
    if (lead_dec) begin
      if (pre.hex && char_byte == CH_ZERO) begin
        fed.phase = PH_HEX0;
      end else if (is_dig) begin
        fed.phase = PH_DIGITS;
        do_add    = 1'b1;
      end else begin
        fed.acc   = '0;
        fed.phase = ln_eff ? PH_DONE : PH_JUNK;
      end
    end
    if (run) begin
      if (is_dig) begin
        fed.phase = PH_DIGITS;
        do_add    = 1'b1;
      end else begin
        fed.phase = (char_byte == CH_LF) ? PH_DONE : PH_JUNK;
      end
    end
    if (do_add && !pre.sat) begin
      if (add_ovf) begin
        fed.sat = 1'b1;
      end else begin
        fed.acc = wide[63:0];
      end
    end
  end

  // The "0x" prefix itself never reaches the converter.
  always_comb begin
    st_next = fed;
    if (st.phase == PH_FIRST && char_byte == CH_ZERO) begin
      st_next       = st;
      st_next.phase = PH_PFX0;
    end else if (st.phase == PH_PFX0 && char_byte == CH_LOWER_X) begin
      st_next = st;
      if (cfg.base_mode == BASE_DEC) begin
        st_next.phase = PH_ERR0X;
      end else begin
        st_next.phase = PH_WS;
        st_next.hex   = 1'b1;
      end
    end
  end

  // Terminator: form the value and every status that does not need the limits.
  always_comb begin
    if (pre.phase == PH_ERR0X) begin
      early = ST_HEX_IN_DEC;
    end else if (pre.phase == PH_JUNK || pre.phase == PH_AFTERX) begin
      early = ST_JUNK;
    end else if (((pre.phase == PH_WS && pre.lead_seen) || pre.phase == PH_SIGNED) &&
                 !pre.lead_nl) begin
      early = ST_JUNK;
    end else begin
      early = ST_OK;
    end
    zero_it = (pre.phase == PH_FIRST) || (pre.phase == PH_WS) ||
              (pre.phase == PH_SIGNED) || (pre.phase == PH_HEX0);
    fa    = zero_it ? '0 : pre.acc;
    fs    = zero_it ? 1'b0 : pre.sat;
    neg_a = 64'd0 - fa;
    if (cfg.signed_mode) begin
      if (pre.neg) begin
        v = (fs || (fa[63] && |fa[62:0])) ? S64_MIN : neg_a;
      end else begin
        v = (fs || fa[63]) ? S64_MAX : fa;
      end
      v_ovf = (v == S64_MAX);
    end else begin
      v     = fs ? U64_ALL : (pre.neg ? neg_a : fa);
      v_ovf = (v == U64_ALL);
    end
    fin_next.value       = v;
    fin_next.signed_mode = cfg.signed_mode;
    if (early != ST_OK) begin
      fin_next.status = early;
    end else if (v_ovf) begin
      fin_next.status = ST_OVERFLOW;
    end else begin
      fin_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PST_RESET;
    end else if (char_take) begin
      st <= is_nul ? PST_RESET : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_free) begin
      fin_valid <= char_valid && is_nul;
    end
  end

  always_ff @(posedge clk) begin
    if (char_take && is_nul) begin
      fin <= fin_next;
    end
  end

endmodule

>>> sv/isp_check.sv
`timescale 1ns / 1ps

module isp_check import isp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fin_valid,
  input  fin_t        fin,
  input  cfg_t        cfg,
  input  logic        result_ready,
  output logic        check_ready,
  output logic        result_valid,
  output logic [63:0] parsed_value,
  output logic [2:0]  status_code
);

  logic [63:0] flip;
  logic [63:0] vk;
  logic [63:0] mink;
  logic [63:0] maxk;
  status_t     status;

  assign check_ready = !result_valid || result_ready;

  // Signed comparison is done as unsigned with the sign bits flipped.
  assign flip = fin.signed_mode ? S64_MIN : 64'd0;
  assign vk   = fin.value ^ flip;
  assign mink = cfg.min_value ^ flip;
  assign maxk = cfg.max_value ^ flip;

  always_comb begin
    if (fin.status != ST_OK) begin
      status = fin.status;
    end else if (vk < mink) begin
      status = ST_BELOW_MIN;
    end else if (vk > maxk) begin
      status = ST_ABOVE_MAX;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (check_ready) begin
      result_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (check_ready && fin_valid) begin
      parsed_value <= (status == ST_OK) ? fin.value : 64'd0;
      status_code  <= status;
    end
  end

endmodule

>>> sv/integer_string_parser_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                          Word
// char      in         char_valid / char_ready            char_byte
// result    out        result_valid / result_ready        parsed_value, status_code
// config    in         psel, penable, pwrite, pready       paddr, pwdata -> prdata
//
// One character word is taken every cycle unless a held zero byte waits on a
// full result path; the digit multiply-add in the parse stage sets that rate.
// Reset (rst, synchronous) empties the pipeline, returns the parse to the start
// of a string and loads the register defaults; there is no clearing pass.
// A stalled result word holds the output register while the two stages behind
// it keep filling; char_ready falls only when every stage is occupied.
module integer_string_parser_core import isp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_ready,
  input  logic [7:0]        char_byte,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [63:0]       parsed_value,
  output logic [2:0]        status_code,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  logic       held_valid;
  logic [7:0] held_char;
  logic       char_take;
  logic       check_ready;
  logic       fin_valid;
  fin_t       fin;

  // Register file on the configuration port. Writes are expected only while
  // the block is idle, so the parse and check stages read it directly.
  isp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register. The parse stage takes a held character every cycle
  // unless it is the terminator and the result path is full.
  assign char_ready = !held_valid || char_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (char_ready) begin
      held_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      held_char <= char_byte;
    end
  end

  // Parse stage: prefix handling, whitespace, sign and digit accumulation,
  // and on the zero byte the value with the early status codes.
  isp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (held_valid),
    .char_byte   (held_char),
    .cfg         (cfg),
    .check_ready (check_ready),
    .char_take   (char_take),
    .fin_valid   (fin_valid),
    .fin         (fin)
  );

  // Range check against the limits and the output register.
  isp_check u_check (
    .clk          (clk),
    .rst          (rst),
    .fin_valid    (fin_valid),
    .fin          (fin),
    .cfg          (cfg),
    .result_ready (result_ready),
    .check_ready  (check_ready),
    .result_valid (result_valid),
    .parsed_value (parsed_value),
    .status_code  (status_code)
  );

endmodule

>>> sv/isp_checker.sv
`timescale 1ns / 1ps
`include "integer_string_parser_core_macros.svh"

module isp_checker import isp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              char_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic [63:0]       parsed_value,
  input logic [2:0]        status_code,
  input logic              psel,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [63:0]       prdata
);

  // A waiting result word must not change under the consumer.
  `ISP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(parsed_value) && $stable(status_code), "result word changed while stalled")

  // Any failing status carries a zero value.
  `ISP_ASSERT_NOW(a_value_zero_on_error, result_valid && status_code != ST_OK, parsed_value == 64'd0, "nonzero value with error status")

  // The sign-mode register reads back as a single bit.
  `ISP_ASSERT_NOW(a_signed_mode_read, psel && !pwrite && paddr[ADDR_W-1:3] == REG_SIGNED_MODE, prdata[63:1] == 63'd0, "signed_mode readback too wide")

  // Leaving reset, the pipeline is empty and a character can be taken.
  `ISP_ASSERT_NOW(a_empty_after_reset, $past(rst), char_ready && !result_valid, "pipeline not empty after reset")

endmodule

bind integer_string_parser_core isp_checker u_isp_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for integer_string_parser_core.
//
// A clocked driver offers character words from a queue that the initial block
// fills. Every accepted word goes straight into a behavioural copy of the
// parser kept here, which predicts the result word due when a string's zero
// byte is taken. A clocked monitor takes result words and compares each one,
// field by field, with the oldest prediction. The register port is written
// only while the parser is idle, apart from one deliberate write in the middle
// of a string, made once the pipeline has drained.
module testbench;
  import isp_pkg::*;

  localparam logic [1:0] BASE_AUTO  = 2'd0;
  localparam logic [1:0] BASE_SPARE = 2'd3;

  // Quiet time for the result word to leave after its zero byte, before a
  // register write or the end of the run.
  localparam int DRAIN_CYCLES = 8;

  // The slowest correct run stalls on a 51 % idle sender or receiver, plus
  // the drain and the four register writes between phases. A quiet spell
  // of STALL_LIMIT can only mean a hang.
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic [63:0] value;
    status_t     status;
  } result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              char_valid = 1'b0;
  logic              char_ready;
  logic [7:0]        char_byte = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [63:0]       parsed_value;
  logic [2:0]        status_code;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;

  integer_string_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_byte    (char_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .parsed_value (parsed_value),
    .status_code  (status_code),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard storage.
  logic [7:0]  chars_to_send[$];
  result_t     expected_results[$];
  result_t     want;
  string       hex_set = "0123456789abcdefABCDEF";

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          failures = 0;
  int          chars_taken = 0;
  int          results_checked = 0;
  int          settings_applied = 0;
  int          quiet_cycles = 0;
  int          status_tally [0:7];

  // Behavioural copy of the parser: the register values and the parse state.
  cfg_t        live_cfg;
  logic [63:0] acc_value;
  phase_t      parse_at;
  logic        radix16;
  logic        minus_seen;
  logic        clipped;
  logic        first_seen;
  logic        first_is_lf;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_parse();
    acc_value   = '0;
    parse_at    = PH_FIRST;
    radix16     = 1'b0;
    minus_seen  = 1'b0;
    clipped     = 1'b0;
    first_seen  = 1'b0;
    first_is_lf = 1'b0;
  endfunction

  // Whitespace as the C library sees it: space and TAB through CR.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Value of a digit or letter in any radix up to 36; 99 for anything else.
  function automatic int unsigned char_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "z") return c - "a" + 10;
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    return 99;
  endfunction

  // Multiply-add one digit, or latch saturation once the next step would
  // carry past 64 bits. After saturation further digits are swallowed.
  function automatic void add_digit(input int unsigned d);
    logic [63:0] radix, cutoff, cutlim;
    radix  = radix16 ? 64'd16 : 64'd10;
    cutoff = U64_ALL / radix;
    cutlim = U64_ALL % radix;
    if (!clipped) begin
      if (acc_value > cutoff || (acc_value == cutoff && 64'(d) > cutlim)) begin
        clipped = 1'b1;
      end else begin
        acc_value = acc_value * radix + 64'(d);
      end
    end
  endfunction

  // The radix is fixed once the first character that can decide it arrives.
  function automatic void start_converter();
    radix16  = (live_cfg.base_mode == BASE_HEX);
    parse_at = PH_WS;
  endfunction

  // One character of the text that follows any leading prefix.
  function automatic void feed_converter(input logic [7:0] c);
    int unsigned d;
    logic        is_dig;
    logic        in_run;
    d      = char_digit(c);
    is_dig = d < (radix16 ? 16 : 10);
    in_run = 1'b0;
    if (!first_seen) begin
      first_seen  = 1'b1;
      first_is_lf = (c == CH_LF);
    end
    case (parse_at)
      PH_WS, PH_SIGNED: begin
        if (parse_at == PH_WS && is_blank(c)) begin
          // Leading whitespace is skipped.
        end else if (parse_at == PH_WS && (c == CH_PLUS || c == CH_MINUS)) begin
          minus_seen = (c == CH_MINUS);
          parse_at   = PH_SIGNED;
        end else if (radix16 && c == CH_ZERO) begin
          parse_at = PH_HEX0;
        end else if (is_dig) begin
          parse_at = PH_DIGITS;
          add_digit(d);
        end else begin
          // Nothing converted: fine only if the text opened with a newline.
          acc_value = '0;
          parse_at  = first_is_lf ? PH_DONE : PH_JUNK;
        end
      end
      PH_HEX0: begin
        if (c == CH_LOWER_X || c == CH_UPPER_X) begin
          parse_at = PH_AFTERX;
        end else begin
          parse_at  = PH_DIGITS;
          acc_value = '0;
          in_run    = 1'b1;
        end
      end
      PH_AFTERX: begin
        if (is_dig) begin
          parse_at = PH_DIGITS;
          add_digit(d);
        end else begin
          parse_at = PH_JUNK;
        end
      end
      PH_DIGITS: in_run = 1'b1;
      default: ;
    endcase
    if (in_run) begin
      if (is_dig) begin
        add_digit(d);
      end else begin
        parse_at = (c == CH_LF) ? PH_DONE : PH_JUNK;
      end
    end
  endfunction

  // The zero byte: fold sign and saturation into a value, then run the
  // overflow check and the range checks against the current limits.
  function automatic void close_string(output result_t r);
    logic [63:0] v;
    r.value = '0;
    if (parse_at == PH_ERR0X) begin
      r.status = ST_HEX_IN_DEC;
    end else if (parse_at == PH_JUNK || parse_at == PH_AFTERX) begin
      r.status = ST_JUNK;
    end else if (((parse_at == PH_WS && first_seen) || parse_at == PH_SIGNED) &&
                 !first_is_lf) begin
      r.status = ST_JUNK;
    end else begin
      if (parse_at == PH_FIRST || parse_at == PH_WS || parse_at == PH_SIGNED ||
          parse_at == PH_HEX0) begin
        acc_value = '0;
        clipped   = 1'b0;
      end
      if (live_cfg.signed_mode) begin
        if (minus_seen) begin
          v = (clipped || acc_value > S64_MIN) ? S64_MIN : 64'd0 - acc_value;
        end else begin
          v = (clipped || acc_value > S64_MAX) ? S64_MAX : acc_value;
        end
        // Flipping the top bit turns a signed compare into an unsigned one.
        if (v == S64_MAX) begin
          r.status = ST_OVERFLOW;
        end else if ((v ^ S64_MIN) < (live_cfg.min_value ^ S64_MIN)) begin
          r.status = ST_BELOW_MIN;
        end else if ((v ^ S64_MIN) > (live_cfg.max_value ^ S64_MIN)) begin
          r.status = ST_ABOVE_MAX;
        end else begin
          r.status = ST_OK;
          r.value  = v;
        end
      end else begin
        v = clipped ? U64_ALL : (minus_seen ? 64'd0 - acc_value : acc_value);
        if (v == U64_ALL) begin
          r.status = ST_OVERFLOW;
        end else if (v < live_cfg.min_value) begin
          r.status = ST_BELOW_MIN;
        end else if (v > live_cfg.max_value) begin
          r.status = ST_ABOVE_MAX;
        end else begin
          r.status = ST_OK;
          r.value  = v;
        end
      end
    end
  endfunction

  // One accepted character word. A leading "0" is held back until the next
  // character shows whether it opens a "0x" prefix.
  function automatic void parse_char(input logic [7:0] c);
    result_t r;
    logic    consumed;
    consumed = 1'b0;
    if (parse_at == PH_PFX0) begin
      if (c == CH_LOWER_X) begin
        if (live_cfg.base_mode == BASE_DEC) begin
          parse_at = PH_ERR0X;
        end else begin
          parse_at = PH_WS;
          radix16  = 1'b1;
        end
        consumed = 1'b1;
      end else begin
        start_converter();
        feed_converter(CH_ZERO);
      end
    end else if (parse_at == PH_FIRST && c != CH_NUL) begin
      if (c == CH_ZERO) begin
        parse_at = PH_PFX0;
        consumed = 1'b1;
      end else begin
        start_converter();
      end
    end
    if (!consumed) begin
      if (c != CH_NUL) begin
        feed_converter(c);
      end else begin
        close_string(r);
        expected_results.push_back(r);
        reset_parse();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Character driver: valid is raised at random, held until the word is taken.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      if (char_valid && char_ready) begin
        parse_char(char_byte);
        chars_taken++;
      end
      if (!char_valid || char_ready) begin
        if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          char_valid <= 1'b1;
          char_byte  <= chars_to_send.pop_front();
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random back-pressure, in-order comparison per field.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("Result word with no string pending: parsed_value %h, status_code %0d",
                 parsed_value, status_code);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (parsed_value !== want.value) begin
            $error("parsed_value: expected %h, actual %h", want.value, parsed_value);
            failures++;
          end
          if (status_code !== want.status) begin
            $error("status_code: expected %0d, actual %0d", want.status, status_code);
            failures++;
          end
          status_tally[status_code]++;
          results_checked++;
        end
      end
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any word moving on either channel, or a register access,
  // counts as progress.
  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (result_valid && result_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Holds the sender back until every queued word has gone, every predicted
  // result has come out, and the pipeline has had time to empty.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (chars_to_send.size() != 0 || char_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Setup cycle then access cycle; the register is written at the edge where
  // the access phase meets pready.
  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BASE_MODE:   live_cfg.base_mode   = val[1:0];
      REG_SIGNED_MODE: live_cfg.signed_mode = val[0];
      REG_MIN_VALUE:   live_cfg.min_value   = val;
      REG_MAX_VALUE:   live_cfg.max_value   = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [1:0] base, input logic sgn,
                                input logic [63:0] lo, input logic [63:0] hi);
    wait_until_idle();
    write_reg(REG_BASE_MODE, 64'(base));
    write_reg(REG_SIGNED_MODE, 64'(sgn));
    write_reg(REG_MIN_VALUE, lo);
    write_reg(REG_MAX_VALUE, hi);
    settings_applied++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) chars_to_send.push_back(s[i]);
    chars_to_send.push_back(CH_NUL);
  endtask

  // Mostly well-formed numbers with random prefix, whitespace, sign, digits
  // and tail, some close to the 64-bit limits; the rest is raw noise.
  task automatic queue_random_string();
    int unsigned roll, n;
    logic        hexy;
    string       lim;
    roll = $urandom_range(99);
    hexy = (live_cfg.base_mode == BASE_HEX);
    if (roll < 12) begin
      // Arbitrary non-zero bytes, so that every bit of the word toggles.
      repeat ($urandom_range(8)) chars_to_send.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(99) < (live_cfg.base_mode == BASE_DEC ? 5 : 30)) begin
        chars_to_send.push_back(CH_ZERO);
        chars_to_send.push_back(CH_LOWER_X);
        hexy = (live_cfg.base_mode != BASE_DEC);
      end
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 3)) begin
          n = $urandom_range(8, 13);
          chars_to_send.push_back(n == 8 ? CH_SPACE : CH_TAB + 8'(n - 9));
        end
      end
      if ($urandom_range(99) < 25) begin
        chars_to_send.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      end
      if (hexy && $urandom_range(99) < 10) begin
        chars_to_send.push_back(CH_ZERO);
        chars_to_send.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
      end
      if (roll < 22) begin
        n = $urandom_range(3);
        if (hexy) begin
          case (n)
            0:       lim = "ffffffffffffffff";
            1:       lim = "7fffffffffffffff";
            2:       lim = "8000000000000000";
            default: lim = "10000000000000000";
          endcase
        end else begin
          case (n)
            0:       lim = "18446744073709551615";
            1:       lim = "18446744073709551614";
            2:       lim = "9223372036854775807";
            default: lim = "9223372036854775808";
          endcase
        end
        for (int i = 0; i < lim.len(); i++) chars_to_send.push_back(lim[i]);
      end else begin
        n = $urandom_range(99);
        n = (n < 70) ? $urandom_range(1, 5) : (n < 90) ? $urandom_range(6, 15) :
            $urandom_range(16, 22);
        repeat (n) begin
          chars_to_send.push_back(hexy ? hex_set[$urandom_range(21)] :
                                         CH_ZERO + 8'($urandom_range(9)));
        end
      end
      n = $urandom_range(99);
      if (n < 12) begin
        chars_to_send.push_back(CH_LF);
        repeat ($urandom_range(3)) chars_to_send.push_back(8'($urandom_range(32, 126)));
      end else if (n < 24) begin
        chars_to_send.push_back(8'($urandom_range(1, 255)));
      end
    end
    chars_to_send.push_back(CH_NUL);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned lo, span;
    logic [63:0] mn, mx;
    int          target;

    foreach (status_tally[i]) status_tally[i] = 0;
    reset_parse();
    live_cfg.base_mode   = BASE_AUTO;
    live_cfg.signed_mode = 1'b0;
    live_cfg.min_value   = '0;
    live_cfg.max_value   = U64_ALL;
    send_idle_pct = 32;
    recv_idle_pct = 51;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: auto radix, unsigned, full range.
    apply_settings(BASE_AUTO, 1'b0, '0, U64_ALL);
    queue_text("");                       // empty string
    queue_text("0");
    queue_text(" \t+42");
    queue_text("-1");                     // wraps to all ones, so overflow
    queue_text("18446744073709551615");   // exact maximum
    queue_text("18446744073709551616");   // saturates
    queue_text("12\nq");                  // newline tail is allowed
    queue_text("12z");                    // trailing junk
    queue_text("\n");                     // no digits, but text opens with a newline
    queue_text("-");                      // sign with nothing after it
    queue_text("0x1F");
    queue_text("0x0x");                   // second prefix with no digit after it

    // A register write in the middle of a string: the held-back "0" is
    // resolved only when the "x" arrives, by which time decimal mode is set.
    chars_to_send.push_back(CH_ZERO);
    wait_until_idle();
    write_reg(REG_BASE_MODE, 64'(BASE_DEC));
    queue_text("x5");

    // Hexadecimal, signed, full signed range.
    apply_settings(BASE_HEX, 1'b1, S64_MIN, S64_MAX);
    queue_text("0x0XaB");
    queue_text("-8000000000000000");      // most negative value, exactly
    queue_text("7fffffffffffffff");       // signed maximum is overflow
    queue_text("-80000000000000001");     // negative saturation, not overflow

    // Unused radix code behaves as auto for a prefix and decimal otherwise.
    apply_settings(BASE_SPARE, 1'b0, 64'd100, 64'd200);
    queue_text("0x10");
    queue_text("201");
    queue_text("150");

    // Signed window straddling zero.
    apply_settings(BASE_AUTO, 1'b1, 64'd0 - 64'd5, 64'd5);
    queue_text("-6");
    queue_text("6");
    queue_text("-5");

    // Random part: eight register settings, the extremes among them, each
    // given about 100 character words. Receiver-heavy idling first, then
    // sender-heavy, then none at all.
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 32;
      end
      if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      lo   = $urandom_range(500);
      span = $urandom_range(60000);
      mn   = {$urandom, $urandom} >> $urandom_range(40, 63);
      mx   = mn + ({$urandom, $urandom} >> $urandom_range(20, 50));
      case (p)
        0: apply_settings(BASE_AUTO, 1'b0, '0, U64_ALL);
        1: apply_settings(BASE_DEC, 1'b0, 64'(lo), 64'(lo) + 64'(span));
        2: apply_settings(BASE_HEX, 1'b1, S64_MIN, S64_MAX);
        3: apply_settings(BASE_AUTO, 1'b1, 64'd0 - 64'(lo), 64'(span));
        4: apply_settings(BASE_SPARE, 1'b0, '0, '0);
        5: apply_settings(BASE_HEX, 1'b0, U64_ALL, U64_ALL);
        6: apply_settings(BASE_DEC, 1'b1, S64_MAX, S64_MIN);
        default: apply_settings(BASE_AUTO, 1'b0, mn, mx);
      endcase
      target = chars_taken + 95;
      while (chars_taken + chars_to_send.size() < target) queue_random_string();
    end

    wait_until_idle();
    $display("Checked %0d result words from %0d character words over %0d register settings.",
             results_checked, chars_taken, settings_applied);
    $display("Statuses: ok %0d, prefix in decimal %0d, junk %0d, overflow %0d, below %0d, above %0d.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4], status_tally[5]);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
